// File: sv/ulbp_pkg.sv
// Shared constants, types and the uniform pattern rank table for the LBP coder.
`timescale 1ns / 1ps
`default_nettype none

package ulbp_pkg;

    localparam int unsigned MAX_LINE_WIDTH   = 1024;
    localparam int unsigned WEIGHT_FRAC_BITS = 16;

    localparam int unsigned LINE_ADDR_W = $clog2(MAX_LINE_WIDTH);
    localparam int unsigned LINE_ROWS   = 4;
    localparam int unsigned LANE_W      = $clog2(LINE_ROWS);
    localparam int unsigned WIN_N       = 5;
    localparam int unsigned HALO        = 2;

    localparam int unsigned PIX_W      = 8;
    localparam int unsigned WIDTH_W    = 11;
    localparam int unsigned HEIGHT_W   = 12;
    localparam int unsigned ROW_W      = 12;
    localparam int unsigned COL_W      = 10;
    localparam int unsigned LABEL_W    = 6;
    localparam int unsigned CODE_W     = 8;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 12;

    localparam int unsigned RESET_WIDTH  = 640;
    localparam int unsigned RESET_HEIGHT = 480;
    localparam int unsigned MIN_SIZE     = 5;

    localparam int unsigned NON_UNIFORM = 58;
    localparam int unsigned CODE_COUNT  = 256;

    localparam int unsigned FAR_Q24 = 2878515;
    localparam int unsigned MID_Q24 = 4070835;
    localparam int unsigned W_FAR   =
        (2 * FAR_Q24 + (1 << (24 - WEIGHT_FRAC_BITS))) >> (25 - WEIGHT_FRAC_BITS);
    localparam int unsigned W_MID   =
        (2 * MID_Q24 + (1 << (24 - WEIGHT_FRAC_BITS))) >> (25 - WEIGHT_FRAC_BITS);
    localparam int unsigned W_NEAR  = (1 << WEIGHT_FRAC_BITS) - W_FAR - 2 * W_MID;
    localparam int unsigned SUM_W   = WEIGHT_FRAC_BITS + PIX_W + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef logic [WIN_N-1:0][WIN_N-1:0][PIX_W-1:0] t_win;
    typedef logic [LINE_ROWS-1:0][PIX_W-1:0] t_lines;

    typedef struct packed {
        logic             emit;
        logic             last;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_meta;

    typedef struct packed {
        logic [LABEL_W-1:0] label;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic               last;
    } t_result;

    typedef logic [LABEL_W-1:0] t_rank_lut [CODE_COUNT];

    function automatic int unsigned f_transitions(input int unsigned code);
        logic [CODE_W-1:0] c;
        logic [CODE_W-1:0] x;
        int unsigned n;
        c = CODE_W'(code);
        x = c ^ {c[0], c[CODE_W-1:1]};
        n = 0;
        for (int i = 0; i < CODE_W; i++) begin
            n = n + int'(x[i]);
        end
        return n;
    endfunction

    function automatic t_rank_lut f_build_rank();
        t_rank_lut lut;
        int unsigned rank;
        rank = 0;
        for (int k = 0; k < CODE_COUNT; k++) begin
            if (f_transitions(k) <= 2) begin
                lut[k] = LABEL_W'(rank);
                rank   = rank + 1;
            end else begin
                lut[k] = LABEL_W'(NON_UNIFORM);
            end
        end
        return lut;
    endfunction

    localparam t_rank_lut RANK_LUT = f_build_rank();

endpackage

`default_nettype wire

// File: sv/ulbp_linebuf.sv
// Four-row line store: one word per column, one byte lane per stored row.
`timescale 1ns / 1ps
`default_nettype none

module ulbp_linebuf
    import ulbp_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_en,
    input  wire logic [LINE_ADDR_W-1:0] i_addr,
    input  wire logic [LANE_W-1:0]      i_lane,
    input  wire logic [PIX_W-1:0]       i_pix,
    output t_lines                      o_lines
);

    t_lines r_mem [MAX_LINE_WIDTH];
    t_lines r_rd;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rd                 <= r_mem[i_addr];
            r_mem[i_addr][i_lane] <= i_pix;
        end
    end

    assign o_lines = r_rd;

endmodule

`default_nettype wire

// File: sv/ulbp_window.sv
// 5x5 pixel window fed one column per word from the line store and the new pixel.
`timescale 1ns / 1ps
`default_nettype none

module ulbp_window
    import ulbp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_shift,
    input  wire t_lines            i_lines,
    input  wire logic [LANE_W-1:0] i_lane_base,
    input  wire logic [PIX_W-1:0]  i_pix,
    output t_win                   o_win
);

    t_win r_win;
    logic [WIN_N-1:0][PIX_W-1:0] n_col;

    always_comb begin
        for (int k = 0; k < LINE_ROWS; k++) begin
            n_col[k] = i_lines[LANE_W'(i_lane_base + LANE_W'(k))];
        end
        n_col[WIN_N-1] = i_pix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (i_shift) begin
            for (int rr = 0; rr < WIN_N; rr++) begin
                for (int cc = 0; cc < WIN_N - 1; cc++) begin
                    r_win[rr][cc] <= r_win[rr][cc+1];
                end
                r_win[rr][WIN_N-1] <= n_col[rr];
            end
        end
    end

    assign o_win = r_win;

endmodule

`default_nettype wire

// File: sv/ulbp_sample.sv
// Neighbor sampling: weighted diagonal sums, then the eight-bit compare code.
`timescale 1ns / 1ps
`default_nettype none

module ulbp_sample
    import ulbp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire t_win              i_win,
    input  wire t_meta             i_meta,
    output logic [CODE_W-1:0]      o_code,
    output t_meta                  o_meta
);

    function automatic logic [SUM_W-1:0] f_diag(
        input logic [PIX_W-1:0] far_px,
        input logic [PIX_W-1:0] mid_a,
        input logic [PIX_W-1:0] mid_b,
        input logic [PIX_W-1:0] near_px
    );
        logic [SUM_W-1:0] s;
        s = SUM_W'(W_FAR) * SUM_W'(far_px)
          + SUM_W'(W_MID) * (SUM_W'(mid_a) + SUM_W'(mid_b))
          + SUM_W'(W_NEAR) * SUM_W'(near_px);
        return s;
    endfunction

    logic [3:0][SUM_W-1:0] r_s3_sum;
    logic [3:0]            r_s3_axis;
    logic [PIX_W-1:0]      r_s3_ctr;
    t_meta                 r_s3_meta;

    logic [CODE_W-1:0]     r_s4_code;
    t_meta                 r_s4_meta;

    logic [PIX_W-1:0]      ctr;
    logic [SUM_W-1:0]      thr;
    logic [CODE_W-1:0]     n_code;

    assign ctr = i_win[HALO][HALO];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_meta <= '0;
            r_s4_meta <= '0;
        end else if (i_en) begin
            r_s3_meta <= i_meta;
            r_s4_meta <= r_s3_meta;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s3_ctr     <= ctr;
            r_s3_axis[0] <= i_win[2][0] >= ctr;
            r_s3_axis[1] <= i_win[4][2] >= ctr;
            r_s3_axis[2] <= i_win[2][4] >= ctr;
            r_s3_axis[3] <= i_win[0][2] >= ctr;
            r_s3_sum[0]  <= f_diag(i_win[4][0], i_win[4][1], i_win[3][0], i_win[3][1]);
            r_s3_sum[1]  <= f_diag(i_win[4][4], i_win[4][3], i_win[3][4], i_win[3][3]);
            r_s3_sum[2]  <= f_diag(i_win[0][4], i_win[0][3], i_win[1][4], i_win[1][3]);
            r_s3_sum[3]  <= f_diag(i_win[0][0], i_win[0][1], i_win[1][0], i_win[1][1]);
            r_s4_code    <= n_code;
        end
    end

    always_comb begin
        thr       = SUM_W'(r_s3_ctr) << WEIGHT_FRAC_BITS;
        n_code[0] = r_s3_axis[0];
        n_code[1] = r_s3_sum[0] >= thr;
        n_code[2] = r_s3_axis[1];
        n_code[3] = r_s3_sum[1] >= thr;
        n_code[4] = r_s3_axis[2];
        n_code[5] = r_s3_sum[2] >= thr;
        n_code[6] = r_s3_axis[3];
        n_code[7] = r_s3_sum[3] >= thr;
    end

    assign o_code = r_s4_code;
    assign o_meta = r_s4_meta;

endmodule

`default_nettype wire

// File: sv/uniform_lbp_radius2_pixel_coder.sv
// Usage:
//   Input channel: i_valid / o_stall carry one grey pixel word per unstalled cycle in
//   raster order, with i_frame_start marking row 0, column 0 of a frame.
//   Output channel: o_valid / i_stall carry one label word for every center
//   pixel two rows and two columns in from the frame border: its uniform
//   pattern rank (58 for non-uniform), its row and column, and a flag on the
//   last label of the frame. Border labels are never produced.
//   Frame size is set through i_cfg_we / i_cfg_index / i_cfg_data while the
//   block is idle; it takes effect in the cycle after the write.
//   Throughput: one pixel per clock while o_stall is low, set by the single-port
//   line store read and written once per pixel.
//   Pipeline: the pixel that completes a window is accepted, then passes the line
//   store read, window shift, diagonal sums and code compare registers, and its
//   rank lookup lands in the output register.
//   Reset: synchronous, active low; clears counters, window, pipeline and
//   output valids and restores a 640 x 480 frame size. No clearing pass.
//   Stall: a label that arrives while the output is stalled parks in a skid
//   register; o_stall then rises and the whole pipeline holds until the
//   receiver takes the waiting word.
`timescale 1ns / 1ps
`default_nettype none

module uniform_lbp_radius2_pixel_coder
    import ulbp_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [PIX_W-1:0]      i_pixel_value,
    input  wire logic                  i_frame_start,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [LABEL_W-1:0]         o_pattern_label,
    output logic [ROW_W-1:0]           o_center_row,
    output logic [COL_W-1:0]           o_center_col,
    output logic                       o_frame_last
);

    logic [WIDTH_W-1:0]     r_ew;
    logic [HEIGHT_W-1:0]    r_eh;
    logic [WIDTH_W-1:0]     n_ew;
    logic [HEIGHT_W-1:0]    n_eh;

    logic [LINE_ADDR_W-1:0] r_col;
    logic [HEIGHT_W-1:0]    r_row;
    logic [LINE_ADDR_W-1:0] n_col;
    logic [HEIGHT_W-1:0]    n_row;
    logic [LINE_ADDR_W-1:0] cur_col;
    logic [HEIGHT_W-1:0]    cur_row;
    logic [WIDTH_W:0]       col_inc;
    logic [HEIGHT_W:0]      row_inc;
    logic                   hit;
    t_meta                  n_meta;

    logic                   en;
    logic                   accept;

    logic                   r_s1_valid;
    logic [LANE_W-1:0]      r_s1_lane;
    logic [PIX_W-1:0]       r_s1_pix;
    t_meta                  r_s1_meta;
    t_meta                  r_s2_meta;

    t_lines                 lines;
    t_win                   win;
    logic [CODE_W-1:0]      code;
    t_meta                  s4_meta;

    t_result                p_res;
    logic                   r_out_valid;
    t_result                r_out;
    logic                   r_skid_valid;
    t_result                r_skid;

    assign en      = !r_skid_valid;
    assign accept  = i_valid && en;
    assign o_stall = r_skid_valid;

    always_comb begin
        if (i_cfg_data[WIDTH_W-1:0] < WIDTH_W'(MIN_SIZE)) begin
            n_ew = WIDTH_W'(MIN_SIZE);
        end else if (i_cfg_data[WIDTH_W-1:0] > WIDTH_W'(MAX_LINE_WIDTH)) begin
            n_ew = WIDTH_W'(MAX_LINE_WIDTH);
        end else begin
            n_ew = i_cfg_data[WIDTH_W-1:0];
        end
        if (i_cfg_data[HEIGHT_W-1:0] < HEIGHT_W'(MIN_SIZE)) begin
            n_eh = HEIGHT_W'(MIN_SIZE);
        end else begin
            n_eh = i_cfg_data[HEIGHT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ew <= WIDTH_W'(RESET_WIDTH);
            r_eh <= HEIGHT_W'(RESET_HEIGHT);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_FRAME_WIDTH:  r_ew <= n_ew;
                CFG_FRAME_HEIGHT: r_eh <= n_eh;
                default: ;
            endcase
        end
    end

    always_comb begin
        cur_col = i_frame_start ? '0 : r_col;
        cur_row = i_frame_start ? '0 : r_row;
        col_inc = (WIDTH_W+1)'(cur_col) + 1'b1;
        row_inc = (HEIGHT_W+1)'(cur_row) + 1'b1;
        hit     = cur_row >= HEIGHT_W'(2 * HALO) && cur_col >= LINE_ADDR_W'(2 * HALO)
               && cur_row < r_eh && (WIDTH_W+1)'(cur_col) < (WIDTH_W+1)'(r_ew);
        if (col_inc >= (WIDTH_W+1)'(r_ew)) begin
            n_col = '0;
            n_row = (row_inc >= (HEIGHT_W+1)'(r_eh)) ? '0 : row_inc[HEIGHT_W-1:0];
        end else begin
            n_col = col_inc[LINE_ADDR_W-1:0];
            n_row = cur_row;
        end
        n_meta.emit = accept && hit;
        n_meta.last = row_inc == (HEIGHT_W+1)'(r_eh) && col_inc == (WIDTH_W+1)'(r_ew);
        n_meta.row  = ROW_W'(cur_row - HEIGHT_W'(HALO));
        n_meta.col  = COL_W'(cur_col - LINE_ADDR_W'(HALO));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
            r_s1_meta  <= '0;
            r_s2_meta  <= '0;
        end else if (en) begin
            r_s1_valid <= accept;
            r_s1_meta  <= n_meta;
            r_s2_meta  <= r_s1_meta;
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_lane <= cur_row[LANE_W-1:0];
            r_s1_pix  <= i_pixel_value;
        end
    end

    ulbp_linebuf u_linebuf (
        .i_clk   (i_clk),
        .i_en    (accept),
        .i_addr  (cur_col),
        .i_lane  (cur_row[LANE_W-1:0]),
        .i_pix   (i_pixel_value),
        .o_lines (lines)
    );

    ulbp_window u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_shift     (en && r_s1_valid),
        .i_lines     (lines),
        .i_lane_base (r_s1_lane),
        .i_pix       (r_s1_pix),
        .o_win       (win)
    );

    ulbp_sample u_sample (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_win   (win),
        .i_meta  (r_s2_meta),
        .o_code  (code),
        .o_meta  (s4_meta)
    );

    always_comb begin
        p_res.label = RANK_LUT[code];
        p_res.row   = s4_meta.row;
        p_res.col   = s4_meta.col;
        p_res.last  = s4_meta.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_skid_valid) begin
            if (!r_out_valid || !i_stall) begin
                r_out_valid <= s4_meta.emit;
            end else if (s4_meta.emit) begin
                r_skid_valid <= 1'b1;
            end
        end else if (!i_stall) begin
            r_out_valid  <= 1'b1;
            r_skid_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_valid) begin
            if (!r_out_valid || !i_stall) begin
                r_out <= p_res;
            end else begin
                r_skid <= p_res;
            end
        end else if (!i_stall) begin
            r_out <= r_skid;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_pattern_label = r_out.label;
    assign o_center_row    = r_out.row;
    assign o_center_col    = r_out.col;
    assign o_frame_last    = r_out.last;

endmodule

`default_nettype wire

// File: sv/ulbp_checker.sv
// Port-level checks for the LBP coder and their attachment to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ulbp_checker
    import ulbp_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_stall,
    input wire logic               o_valid,
    input wire logic               i_stall,
    input wire logic [LABEL_W-1:0] o_pattern_label,
    input wire logic [ROW_W-1:0]   o_center_row,
    input wire logic [COL_W-1:0]   o_center_col,
    input wire logic               o_frame_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_pattern_label)
            && $stable(o_center_row) && $stable(o_center_col) && $stable(o_frame_last))
        else $error("stalled output word changed");

    a_label_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_pattern_label <= LABEL_W'(NON_UNIFORM))
        else $error("pattern label out of range");

    a_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_center_row >= ROW_W'(HALO) && o_center_col >= COL_W'(HALO))
        else $error("border label emitted");

    a_stall_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no output word waiting");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("valid or stall set after reset");

endmodule

bind uniform_lbp_radius2_pixel_coder ulbp_checker u_ulbp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_pattern_label (o_pattern_label),
    .o_center_row    (o_center_row),
    .o_center_col    (o_center_col),
    .o_frame_last    (o_frame_last)
);

`default_nettype wire

// File: verif/tb_uniform_lbp_radius2_pixel_coder.sv
// Self-checking testbench for the radius-2 uniform LBP pixel coder.
`timescale 1ns / 1ps

module tb_uniform_lbp_radius2_pixel_coder;
    import ulbp_pkg::*;

    localparam int unsigned LINE_SLOTS    = 1024;
    localparam int unsigned LINE_LANES    = 4;
    localparam int unsigned NOT_UNIFORM   = 58;
    localparam int unsigned FRAC_BITS     = 16;
    localparam longint unsigned WT_FAR    = 11244;
    localparam longint unsigned WT_MID    = 15902;
    localparam longint unsigned WT_NEAR   = 22488;
    localparam int SETTLE_CYCLES          = 16;
    localparam int DRAIN_CYCLES           = 24;
    localparam int RANDOM_PIXELS          = 600;
    localparam int WIDE_PIXELS            = 40;
    localparam int FILL_WIDTH             = 70;
    localparam int RUN_LIMIT              = 4_000_000;
    localparam int PRINT_CAP              = 40;

    typedef enum logic [1:0] {
        STEP_PIXEL,
        STEP_SETTLE,
        STEP_CONFIG
    } t_step_kind;

    typedef struct {
        t_step_kind            kind;
        logic [PIX_W-1:0]      pixel;
        logic                  frame_start;
        t_cfg_idx              cfg_idx;
        logic [CFG_DATA_W-1:0] cfg_data;
    } t_stream_step;

    typedef struct packed {
        logic [LABEL_W-1:0] label;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic               last;
    } t_label_word;

    logic                  clk            = 1'b0;
    logic                  rst_n          = 1'b0;
    logic                  cfg_we         = 1'b0;
    t_cfg_idx              cfg_idx        = CFG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data       = '0;
    logic                  in_valid       = 1'b0;
    logic [PIX_W-1:0]      in_pixel       = '0;
    logic                  in_frame_start = 1'b0;
    logic                  rx_stall       = 1'b0;

    logic                  o_stall;
    logic                  o_valid;
    logic [LABEL_W-1:0]    o_pattern_label;
    logic [ROW_W-1:0]      o_center_row;
    logic [COL_W-1:0]      o_center_col;
    logic                  o_frame_last;

    t_stream_step stream_plan_q [$];
    t_label_word  label_expect_q [$];

    logic [PIX_W-1:0] line_mem [LINE_LANES * LINE_SLOTS];
    logic [PIX_W-1:0] pw [5][5];
    int unsigned      col_cnt;
    int unsigned      row_cnt;
    logic [10:0]      frame_w;
    logic [11:0]      frame_h;

    int  err_count    = 0;
    int  cycle_count  = 0;
    int  send_gap     = 0;
    int  settle_count = 0;
    int  rx_hold      = 0;
    bit  tx_calm      = 1'b0;
    bit  rx_calm      = 1'b0;

    uniform_lbp_radius2_pixel_coder dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_valid         (in_valid),
        .o_stall         (o_stall),
        .i_pixel_value   (in_pixel),
        .i_frame_start   (in_frame_start),
        .o_valid         (o_valid),
        .i_stall         (rx_stall),
        .o_pattern_label (o_pattern_label),
        .o_center_row    (o_center_row),
        .o_center_col    (o_center_col),
        .o_frame_last    (o_frame_last)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    task automatic note_mismatch(input string msg);
        err_count++;
        if (err_count <= PRINT_CAP) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    function automatic int circ_flips(input logic [7:0] v);
        int n;
        n = 0;
        for (int i = 0; i < 8; i++) begin
            if (v[i] != v[(i + 1) % 8]) n++;
        end
        return n;
    endfunction

    function automatic logic [LABEL_W-1:0] uniform_label(input logic [7:0] code);
        int rank;
        rank = 0;
        if (circ_flips(code) > 2) return LABEL_W'(NOT_UNIFORM);
        for (int k = 0; k < code; k++) begin
            if (circ_flips(8'(k)) <= 2) rank++;
        end
        return LABEL_W'(rank);
    endfunction

    function automatic logic diag_at_least(input logic [7:0] far_px, input logic [7:0] mid_a,
                                           input logic [7:0] mid_b, input logic [7:0] near_px,
                                           input logic [7:0] ctr);
        longint unsigned acc;
        acc = WT_FAR * 64'(far_px) + WT_MID * (64'(mid_a) + 64'(mid_b))
            + WT_NEAR * 64'(near_px);
        return acc >= (64'(ctr) << FRAC_BITS);
    endfunction

    function automatic int used_width(input logic [CFG_DATA_W-1:0] data);
        int v;
        v = int'(data[10:0]);
        return (v < 5) ? 5 : ((v > LINE_SLOTS) ? LINE_SLOTS : v);
    endfunction

    function automatic int used_height(input logic [CFG_DATA_W-1:0] data);
        int v;
        v = int'(data[11:0]);
        return (v < 5) ? 5 : v;
    endfunction

    // Shift the window, update the line store, emit a label for interior centers.
    task automatic predict_label(input logic [PIX_W-1:0] pix, input logic fs);
        int unsigned ew;
        int unsigned eh;
        int unsigned r;
        int unsigned c;
        logic [7:0]  ctr;
        logic [7:0]  code;
        t_label_word e;
        ew = used_width(CFG_DATA_W'(frame_w));
        eh = used_height(frame_h);
        if (fs) begin
            col_cnt = 0;
            row_cnt = 0;
        end
        r = row_cnt;
        c = col_cnt % LINE_SLOTS;
        for (int k = 0; k < 5; k++) begin
            for (int j = 0; j < 4; j++) pw[k][j] = pw[k][j + 1];
            pw[k][4] = (k < 4) ? line_mem[((r + k) & 3) * LINE_SLOTS + c] : pix;
        end
        line_mem[(r & 3) * LINE_SLOTS + c] = pix;
        if (r >= 4 && c >= 4 && r < eh && c < ew) begin
            ctr     = pw[2][2];
            code[0] = pw[2][0] >= ctr;
            code[1] = diag_at_least(pw[4][0], pw[4][1], pw[3][0], pw[3][1], ctr);
            code[2] = pw[4][2] >= ctr;
            code[3] = diag_at_least(pw[4][4], pw[4][3], pw[3][4], pw[3][3], ctr);
            code[4] = pw[2][4] >= ctr;
            code[5] = diag_at_least(pw[0][4], pw[0][3], pw[1][4], pw[1][3], ctr);
            code[6] = pw[0][2] >= ctr;
            code[7] = diag_at_least(pw[0][0], pw[0][1], pw[1][0], pw[1][1], ctr);
            e.label = uniform_label(code);
            e.row   = ROW_W'(r - 2);
            e.col   = COL_W'(c - 2);
            e.last  = (r == eh - 1) && (c == ew - 1);
            label_expect_q.push_back(e);
        end
        if (c + 1 >= ew) begin
            col_cnt = 0;
            row_cnt = (r + 1 >= eh) ? 0 : r + 1;
        end else begin
            col_cnt = c + 1;
        end
    endtask

    task automatic plan_pixel(input logic [PIX_W-1:0] pix, input logic fs);
        t_stream_step s;
        s.kind        = STEP_PIXEL;
        s.pixel       = pix;
        s.frame_start = fs;
        s.cfg_idx     = CFG_FRAME_WIDTH;
        s.cfg_data    = '0;
        stream_plan_q.push_back(s);
    endtask

    task automatic plan_config(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        t_stream_step s;
        s.kind        = STEP_CONFIG;
        s.pixel       = '0;
        s.frame_start = 1'b0;
        s.cfg_idx     = idx;
        s.cfg_data    = data;
        stream_plan_q.push_back(s);
    endtask

    task automatic plan_settle();
        t_stream_step s;
        s.kind        = STEP_SETTLE;
        s.pixel       = '0;
        s.frame_start = 1'b0;
        s.cfg_idx     = CFG_FRAME_WIDTH;
        s.cfg_data    = '0;
        stream_plan_q.push_back(s);
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [PIX_W-1:0] shade(input int mode, input logic [PIX_W-1:0] prev);
        int v;
        case (mode)
            1: begin
                v = int'(prev) + $urandom_range(0, 4) - 2;
                if ($urandom_range(0, 19) == 0) v = $urandom_range(0, 255);
            end
            2: begin
                case ($urandom_range(0, 3))
                    0: v = 0;
                    1: v = 128;
                    2: v = 255;
                    default: v = prev;
                endcase
            end
            3: begin
                v = $urandom_range(0, 1) ? 255 : 0;
            end
            default: begin
                v = $urandom_range(0, 255);
            end
        endcase
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return PIX_W'(v);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_width_data();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return CFG_DATA_W'($urandom_range(0, 4));
        if (r < 15) return CFG_DATA_W'(12'h800 | $urandom_range(5, 12));
        if (r < 70) return CFG_DATA_W'($urandom_range(5, 12));
        if (r < 90) return CFG_DATA_W'($urandom_range(13, 40));
        return CFG_DATA_W'($urandom_range(41, 70));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_height_data();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return CFG_DATA_W'($urandom_range(0, 4));
        if (r < 15) return CFG_DATA_W'(4095);
        if (r < 20) return CFG_DATA_W'($urandom_range(100, 4094));
        if (r < 80) return CFG_DATA_W'($urandom_range(5, 10));
        return CFG_DATA_W'($urandom_range(11, 24));
    endfunction

    // Driver: feed pixel words, hold config writes and pauses until the block is idle.
    always @(posedge clk) begin
        logic         took;
        logic         hold;
        logic         we_next;
        t_stream_step head;
        if (rst_n) begin
            if ($urandom_range(0, 299) == 0) tx_calm = !tx_calm;
            took    = in_valid && !o_stall;
            hold    = in_valid && !took;
            we_next = 1'b0;
            if (took) begin
                predict_label(in_pixel, in_frame_start);
                send_gap = (tx_calm || $urandom_range(0, 99) < 55) ? 0 : pick_len();
            end
            if (!hold) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (stream_plan_q.size() > 0) begin
                    head = stream_plan_q[0];
                    if (head.kind == STEP_PIXEL) begin
                        in_pixel       <= head.pixel;
                        in_frame_start <= head.frame_start;
                        hold = 1'b1;
                        void'(stream_plan_q.pop_front());
                    end else if (label_expect_q.size() == 0 && !took) begin
                        if (settle_count < SETTLE_CYCLES) begin
                            settle_count++;
                        end else begin
                            settle_count = 0;
                            if (head.kind == STEP_CONFIG) begin
                                if (head.cfg_idx == CFG_FRAME_WIDTH) begin
                                    frame_w = head.cfg_data[10:0];
                                end else begin
                                    frame_h = head.cfg_data[11:0];
                                end
                                cfg_idx  <= head.cfg_idx;
                                cfg_data <= head.cfg_data;
                                we_next  = 1'b1;
                                send_gap = 4;
                            end
                            void'(stream_plan_q.pop_front());
                        end
                    end else begin
                        settle_count = 0;
                    end
                end
            end
            in_valid <= hold;
            cfg_we   <= we_next;
        end
    end

    // Monitor: take label words, compare with the oldest prediction, randomize stall.
    always @(posedge clk) begin
        t_label_word got;
        t_label_word want;
        if (rst_n) begin
            if ($urandom_range(0, 299) == 0) rx_calm = !rx_calm;
            if (o_valid && !rx_stall) begin
                got = {o_pattern_label, o_center_row, o_center_col, o_frame_last};
                if (label_expect_q.size() == 0) begin
                    note_mismatch($sformatf("unexpected label word: label %0d row %0d col %0d",
                                            got.label, got.row, got.col));
                end else begin
                    want = label_expect_q.pop_front();
                    if (got.label !== want.label)
                        note_mismatch($sformatf("label at (%0d,%0d): got %0d want %0d",
                                                want.row, want.col, got.label, want.label));
                    if (got.row !== want.row)
                        note_mismatch($sformatf("center row: got %0d want %0d",
                                                got.row, want.row));
                    if (got.col !== want.col)
                        note_mismatch($sformatf("center col at row %0d: got %0d want %0d",
                                                want.row, got.col, want.col));
                    if (got.last !== want.last)
                        note_mismatch($sformatf("frame last at (%0d,%0d): got %0b want %0b",
                                                want.row, want.col, got.last, want.last));
                end
            end
            if (rx_hold > 0) begin
                rx_hold--;
                rx_stall <= 1'b1;
            end else begin
                rx_stall <= 1'b0;
                if (!rx_calm && $urandom_range(0, 4) == 0) rx_hold = pick_len();
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT) begin
            $display("FAIL uniform_lbp_radius2_pixel_coder");
            $finish;
        end
    end

    initial begin
        logic [CFG_DATA_W-1:0] w_data;
        logic [CFG_DATA_W-1:0] h_data;
        logic [PIX_W-1:0]      px;
        logic                  fs;
        int                    ew;
        int                    eh;
        int                    frame_px;
        int                    n_px;
        int                    mode;
        int                    rand_px;

        for (int i = 0; i < LINE_LANES * LINE_SLOTS; i++) line_mem[i] = '0;
        for (int k = 0; k < 5; k++) begin
            for (int j = 0; j < 5; j++) pw[k][j] = '0;
        end
        col_cnt = 0;
        row_cnt = 0;
        frame_w = 11'(RESET_WIDTH);
        frame_h = 12'(RESET_HEIGHT);

        // smallest frame via clamping; flat image, all neighbors tie with the center
        plan_config(CFG_FRAME_WIDTH, '0);
        plan_config(CFG_FRAME_HEIGHT, 12'd3);
        for (int i = 0; i < 25; i++) plan_pixel(8'h80, i == 0);
        // wrap into the next frame without a frame start; bright center on black
        for (int i = 0; i < 25; i++) plan_pixel((i == 12) ? 8'hFF : 8'h00, 1'b0);
        // partial frame, then restart mid-frame; striped rows give a non-uniform code
        for (int i = 0; i < 7; i++) plan_pixel(PIX_W'($urandom_range(0, 255)), 1'b0);
        for (int i = 0; i < 25; i++) plan_pixel(((i / 5) % 2 == 0) ? 8'hFF : 8'h00, i == 0);
        plan_settle();

        // widest line, written with all data bits set so the width clamps; no label yet
        plan_config(CFG_FRAME_WIDTH, 12'hFFF);
        plan_config(CFG_FRAME_HEIGHT, 12'd5);
        px = 8'd100;
        for (int i = 0; i < WIDE_PIXELS; i++) begin
            px = shade(1, px);
            plan_pixel(px, i == 0);
        end

        // full frame at the widest random width so every reachable line slot is written
        plan_config(CFG_FRAME_WIDTH, CFG_DATA_W'(FILL_WIDTH));
        for (int i = 0; i < 5 * FILL_WIDTH; i++) begin
            px = shade((i % 70 < 60) ? 1 : 0, px);
            plan_pixel(px, i == 0);
        end

        rand_px = 0;
        while (rand_px < RANDOM_PIXELS) begin
            w_data = pick_width_data();
            h_data = pick_height_data();
            plan_config(CFG_FRAME_WIDTH, w_data);
            plan_config(CFG_FRAME_HEIGHT, h_data);
            ew       = used_width(w_data);
            eh       = used_height(h_data);
            frame_px = ew * eh;
            if (eh > 64) begin
                n_px = ew * $urandom_range(5, 9);
            end else begin
                n_px = frame_px * $urandom_range(1, 3) + $urandom_range(0, ew);
            end
            if (n_px > RANDOM_PIXELS - rand_px) n_px = RANDOM_PIXELS - rand_px;
            mode = $urandom_range(0, 3);
            for (int i = 0; i < n_px; i++) begin
                px = shade(mode, px);
                if (i == 0) begin
                    fs = 1'b1;
                end else if (i % frame_px == 0) begin
                    fs = $urandom_range(0, 1);
                end else begin
                    fs = ($urandom_range(0, 249) == 0);
                end
                plan_pixel(px, fs);
                if ($urandom_range(0, 299) == 0) plan_settle();
                if ($urandom_range(0, 399) == 0) begin
                    if ($urandom_range(0, 1)) begin
                        plan_config(CFG_FRAME_WIDTH, CFG_DATA_W'($urandom_range(0, 16)));
                    end else begin
                        plan_config(CFG_FRAME_HEIGHT, CFG_DATA_W'($urandom_range(0, 16)));
                    end
                end
            end
            rand_px += n_px;
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (stream_plan_q.size() > 0 || in_valid || label_expect_q.size() > 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (label_expect_q.size() != 0) begin
            note_mismatch($sformatf("%0d label words never arrived", label_expect_q.size()));
        end
        if (err_count == 0) begin
            $display("PASS uniform_lbp_radius2_pixel_coder");
        end else begin
            $display("FAIL uniform_lbp_radius2_pixel_coder");
        end
        $finish;
    end

endmodule

// File: uniform_lbp_radius2_pixel_coder.f
sv/ulbp_pkg.sv
sv/ulbp_linebuf.sv
sv/ulbp_window.sv
sv/ulbp_sample.sv
sv/uniform_lbp_radius2_pixel_coder.sv
sv/ulbp_checker.sv
verif/tb_uniform_lbp_radius2_pixel_coder.sv
